### rtl/d2q9mrt_pkg.sv
package d2q9mrt_pkg;

    localparam int DIRECTIONS        = 9;
    localparam int TABLE_DEPTH       = DIRECTIONS * DIRECTIONS;
    localparam int DIR_W             = $clog2(DIRECTIONS);
    localparam int IDX_W             = 7;
    localparam int WORD_W            = 32;
    localparam int FRAC_BITS_DEFAULT = 24;

    // Wide signed width that every saturating operation but the negation is evaluated in.
    localparam int SAT_IN_W = 72;

    // Row of a coefficient index: idx * 57 >> 9 equals idx / 9 for idx below 81.
    localparam int ROW_RECIP = 57;
    localparam int ROW_SHIFT = 9;
    localparam int RECIP_W   = ROW_SHIFT + DIR_W;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_NODE = 1'b1;

    localparam logic [DIR_W-1:0] LAST_DIR = DIR_W'(DIRECTIONS - 1);

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [SAT_IN_W-1:0] SAT_MAX =
        {{(SAT_IN_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN =
        {{(SAT_IN_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic                      kind;
        logic [IDX_W-1:0]          coef_index;
        logic signed [WORD_W-1:0]  coef_value;
        logic signed [WORD_W-1:0]  density;
        logic signed [WORD_W-1:0]  vel_x;
        logic signed [WORD_W-1:0]  vel_y;
        logic signed [WORD_W-1:0]  vel_z;
        logic                      last_node;
    } in_item_t;

    typedef struct packed {
        logic [DIR_W-1:0]          direction;
        logic signed [WORD_W-1:0]  dist_value;
        logic                      last_in_node;
        logic                      mesh_end;
    } out_item_t;

    // Steps of the moment sequencer, one multiplication each.
    typedef enum logic [3:0] {
        STEP_UX2,
        STEP_UY2,
        STEP_UZ2,
        STEP_M3,
        STEP_M4,
        STEP_M1,
        STEP_M2,
        STEP_M5,
        STEP_M6,
        STEP_M7,
        STEP_M8
    } mom_step_t;

    typedef struct packed {
        logic             load_we;
        logic             node_load;
        logic             mom_en;
        mom_step_t        mom_step;
        logic             issue;
        logic [DIR_W-1:0] issue_row;
    } dp_cmd_t;

    typedef struct packed {
        logic advance;
        logic pipe_empty;
    } dp_status_t;

    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic signed [WORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = WORD_MAX;
        end
        else if (v < SAT_MIN) begin
            r = WORD_MIN;
        end
        else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] neg_sat(
        input logic signed [WORD_W-1:0] v
    );
        logic signed [WORD_W-1:0] r;
        if (v == WORD_MIN) begin
            r = WORD_MAX;
        end
        else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic [DIR_W-1:0] coef_row(input logic [IDX_W-1:0] idx);
        logic [RECIP_W-1:0] p;
        p = RECIP_W'(idx) * RECIP_W'(ROW_RECIP);
        return p[ROW_SHIFT +: DIR_W];
    endfunction

    function automatic logic [DIR_W-1:0] coef_col(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] c;
        c = idx - IDX_W'(coef_row(idx)) * IDX_W'(DIRECTIONS);
        return c[DIR_W-1:0];
    endfunction

endpackage

### rtl/d2q9mrt_ram.sv
module d2q9mrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/d2q9mrt_ctrl.sv
module d2q9mrt_ctrl
    import d2q9mrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_kind,
    output logic       item_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MOMENT = 4'b0010,
        ST_ISSUE  = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    mom_step_t        step_reg, step_next;
    logic [DIR_W-1:0] row_reg, row_next;
    logic             accept;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);

    assign cmd.load_we   = accept && (item_kind == KIND_LOAD);
    assign cmd.node_load = accept && (item_kind == KIND_NODE);
    assign cmd.mom_en    = (state_reg == ST_MOMENT);
    assign cmd.mom_step  = step_reg;
    assign cmd.issue     = (state_reg == ST_ISSUE);
    assign cmd.issue_row = row_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.node_load)
                begin
                    state_next = ST_MOMENT;
                    step_next  = STEP_UX2;
                end
            end
            ST_MOMENT:
            begin
                if (step_reg == STEP_M8)
                begin
                    state_next = ST_ISSUE;
                    row_next   = '0;
                end
                else
                begin
                    step_next = mom_step_t'(step_reg + 4'd1);
                end
            end
            ST_ISSUE:
            begin
                // A row leaves only when the lane pipeline moves.
                if (status.advance)
                begin
                    if (row_reg == LAST_DIR)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        row_next = row_reg + DIR_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_UX2;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
        end
    end

endmodule

### rtl/d2q9mrt_dp.sv
module d2q9mrt_dp
    import d2q9mrt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       result_valid,
    input  logic       result_stall,
    output out_item_t  result
);

    localparam int LANE_W = 2 * WORD_W - FRAC_BITS;
    localparam int SUM_W  = LANE_W + DIR_W;
    localparam logic signed [SAT_IN_W-1:0] ONE_FX = SAT_IN_W'(1) <<< FRAC_BITS;
    localparam logic signed [SAT_IN_W-1:0] TWO_FX = SAT_IN_W'(2) <<< FRAC_BITS;

    function automatic logic signed [WORD_W-1:0] fx_mul(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic signed [2*WORD_W-1:0] p;
        p = (2*WORD_W)'(a) * (2*WORD_W)'(b);
        return sat_word(SAT_IN_W'(p >>> FRAC_BITS));
    endfunction

    // Node operands and intermediate moment terms.
    logic signed [WORD_W-1:0] rho_reg, ux_reg, uy_reg, uz_reg;
    logic                     last_node_reg;
    logic signed [WORD_W-1:0] ux2_reg, uy2_reg, uz2_reg, u2x3_reg;
    logic signed [WORD_W-1:0] t1_reg, t2_reg, t7_reg;
    logic signed [WORD_W-1:0] m_reg [DIRECTIONS];

    logic signed [WORD_W-1:0] mul_a, mul_b, mul_res;
    logic signed [WORD_W-1:0] u2xy, u2, u2x3_next;

    // Lane pipeline.
    logic                     advance;
    logic [WORD_W-1:0]        coef_q [DIRECTIONS];
    logic signed [2*WORD_W-1:0] lane_prod [DIRECTIONS];
    logic signed [LANE_W-1:0] lane_reg [DIRECTIONS];
    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [DIR_W-1:0]         s1_dir_reg, s2_dir_reg, s3_dir_reg;
    out_item_t                out_reg;

    logic                     idx_ok;
    logic [DIR_W-1:0]         load_row, load_col;

    always_ff @(posedge clk)
    begin
        if (cmd.node_load)
        begin
            rho_reg       <= item.density;
            ux_reg        <= item.vel_x;
            uy_reg        <= item.vel_y;
            uz_reg        <= item.vel_z;
            last_node_reg <= item.last_node;
        end
    end

    always_comb
    begin
        u2xy      = sat_word(SAT_IN_W'(ux2_reg) + SAT_IN_W'(uy2_reg));
        u2        = sat_word(SAT_IN_W'(u2xy) + SAT_IN_W'(uz2_reg));
        u2x3_next = sat_word((SAT_IN_W'(u2) <<< 1) + SAT_IN_W'(u2));
    end

    always_comb
    begin
        unique case (cmd.mom_step)
            STEP_UX2: begin mul_a = ux_reg;   mul_b = ux_reg;          end
            STEP_UY2: begin mul_a = uy_reg;   mul_b = uy_reg;          end
            STEP_UZ2: begin mul_a = uz_reg;   mul_b = uz_reg;          end
            STEP_M3:  begin mul_a = rho_reg;  mul_b = ux_reg;          end
            STEP_M4:  begin mul_a = rho_reg;  mul_b = neg_sat(ux_reg); end
            STEP_M1:  begin mul_a = rho_reg;  mul_b = t1_reg;          end
            STEP_M2:  begin mul_a = rho_reg;  mul_b = t2_reg;          end
            STEP_M5:  begin mul_a = rho_reg;  mul_b = uy_reg;          end
            STEP_M6:  begin mul_a = rho_reg;  mul_b = neg_sat(uy_reg); end
            STEP_M7:  begin mul_a = rho_reg;  mul_b = t7_reg;          end
            STEP_M8:  begin mul_a = m_reg[3]; mul_b = uy_reg;          end
            default:  begin mul_a = '0;       mul_b = '0;              end
        endcase
        mul_res = fx_mul(mul_a, mul_b);
    end

    // The squared speed terms land in the cycles before they are needed by later steps.
    always_ff @(posedge clk)
    begin
        if (cmd.mom_en)
        begin
            unique case (cmd.mom_step)
                STEP_UX2:
                begin
                    ux2_reg  <= mul_res;
                    m_reg[0] <= rho_reg;
                end
                STEP_UY2: uy2_reg <= mul_res;
                STEP_UZ2: uz2_reg <= mul_res;
                STEP_M3:
                begin
                    m_reg[3] <= mul_res;
                    u2x3_reg <= u2x3_next;
                end
                STEP_M4:
                begin
                    m_reg[4] <= mul_res;
                    t1_reg   <= sat_word(SAT_IN_W'(u2x3_reg) - TWO_FX);
                    t2_reg   <= sat_word(ONE_FX - SAT_IN_W'(u2x3_reg));
                    t7_reg   <= sat_word(SAT_IN_W'(ux2_reg) - SAT_IN_W'(uy2_reg));
                end
                STEP_M1:  m_reg[1] <= mul_res;
                STEP_M2:  m_reg[2] <= mul_res;
                STEP_M5:  m_reg[5] <= mul_res;
                STEP_M6:  m_reg[6] <= mul_res;
                STEP_M7:  m_reg[7] <= mul_res;
                STEP_M8:  m_reg[8] <= mul_res;
                default:
                begin
                end
            endcase
        end
    end

    // Coefficient table: one bank per column, addressed by row.
    assign idx_ok   = (item.coef_index < IDX_W'(TABLE_DEPTH));
    assign load_row = coef_row(item.coef_index);
    assign load_col = coef_col(item.coef_index);

    assign advance = !out_valid_reg || !result_stall;

    for (genvar j = 0; j < DIRECTIONS; j++)
    begin : g_lane
        d2q9mrt_ram #(
            .WIDTH (WORD_W),
            .DEPTH (DIRECTIONS)
        ) u_bank (
            .clk   (clk),
            .we    (cmd.load_we && idx_ok && (load_col == DIR_W'(j))),
            .waddr (load_row),
            .wdata (item.coef_value),
            .re    (advance),
            .raddr (cmd.issue_row),
            .rdata (coef_q[j])
        );

        assign lane_prod[j] = (2*WORD_W)'($signed(coef_q[j])) * (2*WORD_W)'(m_reg[j]);

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                lane_reg[j] <= LANE_W'(lane_prod[j] >>> FRAC_BITS);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < DIRECTIONS; j++)
        begin
            sum_next = sum_next + SUM_W'(lane_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dir_reg           <= cmd.issue_row;
            s2_dir_reg           <= s1_dir_reg;
            s3_dir_reg           <= s2_dir_reg;
            sum_reg              <= sum_next;
            out_reg.direction    <= s3_dir_reg;
            out_reg.dist_value   <= sat_word(SAT_IN_W'(sum_reg));
            out_reg.last_in_node <= (s3_dir_reg == LAST_DIR);
            out_reg.mesh_end     <= (s3_dir_reg == LAST_DIR) && last_node_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign status.advance    = advance;
    assign status.pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg
                               && !out_valid_reg;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/d2q9_mrt_equilibrium.sv
// Load transaction: the coefficient is written at the accepting edge.
// Node transaction: the moment steps through the shared moment multiplier, then nine
// rows through the nine multiply lanes; the results follow one per cycle while
// result_stall is low, and the input stays closed until the lanes have drained.
// Reset clears the controller and pipeline valids; the coefficient table is not
// cleared and every entry must be loaded before a node reads it.
module d2q9_mrt_equilibrium
    import d2q9mrt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    d2q9mrt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    d2q9mrt_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // No new transaction is taken while a result is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |-> !result_valid)
        else $error("input accepted while a result is pending");

    // A node transaction keeps the input closed on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.kind == KIND_NODE) |=> item_stall)
        else $error("input open right after a node transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_in_node) |-> (result.direction == LAST_DIR))
        else $error("node end flag on a direction other than the last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.mesh_end) |-> result.last_in_node)
        else $error("mesh end flag outside the final value of a node");

endmodule

### tb/sv/d2q9_mrt_equilibrium_test.sv
`timescale 1ns / 100ps

module d2q9_mrt_equilibrium_test;
    import d2q9mrt_pkg::*;

    localparam int     FRAC  = FRAC_BITS_DEFAULT;
    localparam longint ONE   = longint'(1) << FRAC;
    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;
    localparam logic signed [WORD_W-1:0] Q_ONE = WORD_W'(ONE);

    typedef logic [DIRECTIONS-1:0][WORD_W-1:0] dist_set_t;

    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        dist_set_t want;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    longint    coef_model [TABLE_DEPTH];
    out_item_t dist_expected [$];
    dir_row_t  directed [$];
    int        mismatches;
    int        nodes_sent;
    int        loads_sent;
    int        results_seen;
    int        rx_seen;
    int        rx_hold;
    bit        no_idle;

    d2q9_mrt_equilibrium dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    initial begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > S_MAX) begin
            return S_MAX;
        end
        if (v < S_MIN) begin
            return S_MIN;
        end
        return v;
    endfunction

    // Fixed point product: exact, floor shift, then saturate.
    function automatic longint qmul(longint a, longint b);
        return sat32((a * b) >>> FRAC);
    endfunction

    function automatic void predict_node(in_item_t it);
        longint    rho;
        longint    ux;
        longint    uy;
        longint    uz;
        longint    ux2;
        longint    uy2;
        longint    u2;
        longint    u2x3;
        longint    acc;
        longint    mom [DIRECTIONS];
        out_item_t r;
        rho  = longint'($signed(it.density));
        ux   = longint'($signed(it.vel_x));
        uy   = longint'($signed(it.vel_y));
        uz   = longint'($signed(it.vel_z));
        ux2  = qmul(ux, ux);
        uy2  = qmul(uy, uy);
        u2   = sat32(sat32(ux2 + uy2) + qmul(uz, uz));
        u2x3 = sat32(3 * u2);
        mom[0] = rho;
        mom[1] = qmul(rho, sat32(u2x3 - 2 * ONE));
        mom[2] = qmul(rho, sat32(ONE - u2x3));
        mom[3] = qmul(rho, ux);
        mom[4] = qmul(rho, sat32(-ux));
        mom[5] = qmul(rho, uy);
        mom[6] = qmul(rho, sat32(-uy));
        mom[7] = qmul(rho, sat32(ux2 - uy2));
        mom[8] = qmul(mom[3], uy);
        for (int i = 0; i < DIRECTIONS; i++) begin
            acc = 0;
            // Row products are shifted one by one and only the sum saturates.
            for (int j = 0; j < DIRECTIONS; j++) begin
                acc += (coef_model[i * DIRECTIONS + j] * mom[j]) >>> FRAC;
            end
            r.direction    = DIR_W'(i);
            r.dist_value   = WORD_W'(sat32(acc));
            r.last_in_node = (i == DIRECTIONS - 1);
            r.mesh_end     = (i == DIRECTIONS - 1) && it.last_node;
            dist_expected.push_back(r);
        end
    endfunction

    function automatic void apply_item(in_item_t it);
        if (it.kind == KIND_LOAD) begin
            loads_sent++;
            if (it.coef_index < TABLE_DEPTH) begin
                coef_model[it.coef_index] = longint'($signed(it.coef_value));
            end
        end
        else begin
            nodes_sent++;
            predict_node(it);
        end
    endfunction

    function automatic void push_typed(in_item_t it, dist_set_t want);
        out_item_t r;
        nodes_sent++;
        for (int i = 0; i < DIRECTIONS; i++) begin
            r.direction    = DIR_W'(i);
            r.dist_value   = want[i];
            r.last_in_node = (i == DIRECTIONS - 1);
            r.mesh_end     = (i == DIRECTIONS - 1) && it.last_node;
            dist_expected.push_back(r);
        end
    endfunction

    function automatic in_item_t make_load(int idx, logic signed [WORD_W-1:0] value);
        in_item_t it;
        it.kind       = KIND_LOAD;
        it.coef_index = IDX_W'(idx);
        it.coef_value = value;
        it.density    = $urandom;
        it.vel_x      = $urandom;
        it.vel_y      = $urandom;
        it.vel_z      = $urandom;
        it.last_node  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t make_node(
        logic signed [WORD_W-1:0] rho,
        logic signed [WORD_W-1:0] ux,
        logic signed [WORD_W-1:0] uy,
        logic signed [WORD_W-1:0] uz,
        logic                     last
    );
        in_item_t it;
        it.kind       = KIND_NODE;
        it.coef_index = IDX_W'($urandom);
        it.coef_value = $urandom;
        it.density    = rho;
        it.vel_x      = ux;
        it.vel_y      = uy;
        it.vel_z      = uz;
        it.last_node  = last;
        return it;
    endfunction

    function automatic dir_row_t dir_row(in_item_t stim, logic typed, dist_set_t want);
        dir_row_t r;
        r.stim  = stim;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Mostly values within a few units, with extremes and full-range words mixed in.
    function automatic logic signed [WORD_W-1:0] rand_word(int odds);
        case ($urandom_range(0, odds))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return $urandom;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp_v);
        mismatches++;
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, exp_v);
    endtask

    task automatic send_item(in_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall) begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk) begin : result_check
        out_item_t want;
        if (rst_n && result_valid && !result_stall) begin
            results_seen++;
            if (dist_expected.size() == 0) begin
                report_mismatch("unexpected result, direction", result.direction, -1);
            end
            else begin
                want = dist_expected.pop_front();
                if (result.direction !== want.direction) begin
                    report_mismatch("direction", result.direction, want.direction);
                end
                if (result.dist_value !== want.dist_value) begin
                    report_mismatch("dist_value", result.dist_value, want.dist_value);
                end
                if (result.last_in_node !== want.last_in_node) begin
                    report_mismatch("last_in_node", result.last_in_node, want.last_in_node);
                end
                if (result.mesh_end !== want.mesh_end) begin
                    report_mismatch("mesh_end", result.mesh_end, want.mesh_end);
                end
            end
        end
    end

    // A fresh hold is drawn after every accepted result.
    always @(negedge clk) begin
        if (results_seen != rx_seen) begin
            rx_seen = results_seen;
            rx_hold = no_idle ? 0 : $urandom_range(0, 4);
        end
        if (rx_hold > 0) begin
            result_stall <= 1'b1;
            rx_hold--;
        end
        else begin
            result_stall <= !no_idle && ($urandom_range(0, 7) == 0);
        end
    end

    initial begin
        in_item_t  it;
        dir_row_t  row;
        dist_set_t zero_dist;
        dist_set_t unit_dist;
        int        idx;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        no_idle      = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // The table is undefined after reset, so every coefficient is written
        // (identity matrix) before the first node transaction.
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            it = make_load(k, (k / DIRECTIONS == k % DIRECTIONS) ? Q_ONE : '0);
            send_item(it);
            apply_item(it);
        end

        // With the identity matrix each distribution value equals its moment.
        zero_dist    = '0;
        unit_dist    = '0;
        unit_dist[0] = Q_ONE;
        unit_dist[1] = -2 * Q_ONE;
        unit_dist[2] = Q_ONE;
        directed.push_back(dir_row(make_node('0, WORD_MAX, WORD_MIN, WORD_MAX, 1'b1), 1'b1,
                                   zero_dist));
        directed.push_back(dir_row(make_node(Q_ONE, '0, '0, '0, 1'b0), 1'b1, unit_dist));
        directed.push_back(dir_row(make_node(Q_ONE, WORD_MIN, '0, '0, 1'b0), 1'b0, '0));
        directed.push_back(dir_row(make_node(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 1'b1),
                                   1'b0, '0));
        directed.push_back(dir_row(make_node(WORD_MIN, WORD_MIN, WORD_MAX, '0, 1'b0), 1'b0,
                                   '0));
        directed.push_back(dir_row(make_node(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1),
                                   1'b0, '0));
        directed.push_back(dir_row(make_node(-Q_ONE, Q_ONE / 2, -Q_ONE / 4, Q_ONE / 8, 1'b0),
                                   1'b0, '0));
        // Loads beyond the table must leave it untouched.
        directed.push_back(dir_row(make_load(TABLE_DEPTH, WORD_MAX), 1'b0, '0));
        directed.push_back(dir_row(make_load(127, WORD_MIN), 1'b0, '0));
        directed.push_back(dir_row(make_node(Q_ONE, '0, '0, '0, 1'b1), 1'b1, unit_dist));
        directed.push_back(dir_row(make_load(0, WORD_MIN), 1'b0, '0));
        directed.push_back(dir_row(make_load(TABLE_DEPTH - 1, WORD_MAX), 1'b0, '0));
        directed.push_back(dir_row(make_load(4, WORD_MAX), 1'b0, '0));
        directed.push_back(dir_row(make_load(76, WORD_MIN), 1'b0, '0));
        directed.push_back(dir_row(make_node(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, 1'b0),
                                   1'b0, '0));
        directed.push_back(dir_row(make_node(WORD_MIN, 32'sd1, -32'sd1, 32'sd1, 1'b1), 1'b0,
                                   '0));
        directed.push_back(dir_row(make_node(3 * Q_ONE, Q_ONE / 3, Q_ONE / 5, '0, 1'b0), 1'b0,
                                   '0));
        directed.push_back(dir_row(make_load(40, -Q_ONE), 1'b0, '0));
        directed.push_back(dir_row(make_node(Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 1'b1), 1'b0, '0));

        foreach (directed[r]) begin
            row = directed[r];
            send_item(row.stim);
            if (row.typed) begin
                push_typed(row.stim, row.want);
            end
            else begin
                apply_item(row.stim);
            end
        end

        for (int n = 0; n < 170; n++) begin
            if (n % 45 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 3) == 0) begin
                idx = ($urandom_range(0, 9) == 0) ? $urandom_range(TABLE_DEPTH, 127)
                                                  : $urandom_range(0, TABLE_DEPTH - 1);
                it = make_load(idx, rand_word(19));
            end
            else begin
                it = make_node(rand_word(7), rand_word(7), rand_word(7), rand_word(7),
                               1'($urandom_range(0, 1)));
            end
            send_item(it);
            apply_item(it);
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (dist_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Sent %0d node and %0d coefficient load transactions.", nodes_sent, loads_sent);
        $display("Checked %0d distribution values against the predictor.", results_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end
        else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
